// ===== rtl/bavg_pkg.sv =====
// Shared types and constants for the block average decimator.
package bavg_pkg;

	localparam int SAMPLE_W = 24;
	localparam int GSIZE_W  = 9;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} bavg_state_t;

endpackage

// ===== rtl/bavg_front.sv =====
// Front end: sample intake, running sum and group count, job push on group close.
module bavg_front #(
	parameter int MAX_GROUP = 256,
	parameter int CNT_W     = 8,
	parameter int SUM_W     = 32,
	parameter int G_W       = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_ready,
	input  bavg_pkg::sample_t       sample,
	input  logic [G_W-1:0]          group_eff,
	input  logic                    job_space,
	output logic                    job_push,
	output logic signed [SUM_W-1:0] job_sum,
	output logic [G_W-1:0]          job_group
);

	localparam int CMP_W = (G_W > CNT_W + 1) ? G_W : CNT_W + 1;

	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W:0]          cnt_next;
	logic signed [SUM_W-1:0] sum_next;
	logic                    take;
	logic                    close;

	assign sample_ready = job_space;
	assign take         = sample_valid & job_space;
	assign cnt_next     = {1'b0, count_q} + 1'b1;
	assign sum_next     = sum_q + SUM_W'(sample);
	assign close        = CMP_W'(cnt_next) >= CMP_W'(group_eff);

	assign job_push  = take & close;
	assign job_sum   = sum_next;
	assign job_group = group_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (take) begin
			if (close) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= cnt_next[CNT_W-1:0];
				sum_q   <= sum_next;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) < MAX_GROUP)
		else $error("group count reached the maximum group size");

	a_clear_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> (count_q == '0 && sum_q == '0))
		else $error("sum and count not cleared after group close");

endmodule

// ===== rtl/bavg_fifo.sv =====
// Two-entry job queue between the accumulator and the divider.
module bavg_fifo #(
	parameter int W = 41
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         space,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign space     = count_q != CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push & space;
	assign do_pop    = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("job pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("queue fill count out of range");

endmodule

// ===== rtl/bavg_div.sv =====
// Back end: serial signed divide of the group sum and the output register.
module bavg_div #(
	parameter int SUM_W = 32,
	parameter int G_W   = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	output logic                    job_ready,
	input  logic signed [SUM_W-1:0] job_sum,
	input  logic [G_W-1:0]          job_group,
	output logic                    mean_valid,
	input  logic                    mean_ready,
	output bavg_pkg::sample_t       mean
);

	localparam int IT_W = $clog2(SUM_W);

	bavg_pkg::bavg_state_t state_q;
	bavg_pkg::bavg_state_t state_d;

	logic [IT_W-1:0]    iter_q;
	logic [SUM_W-1:0]   dvd_q;
	logic [G_W:0]       rem_q;
	logic [G_W-1:0]     div_q;
	logic               neg_q;
	bavg_pkg::sample_t  mean_q;
	logic               out_valid_q;

	logic               load_job;
	logic               step;
	logic               load_out;
	logic               last_iter;
	logic [G_W:0]       rem_sh;
	logic               ge;
	logic [SUM_W-1:0]   mag;
	logic [SUM_W-1:0]   res;

	assign last_iter = 32'(iter_q) == SUM_W - 1;
	assign rem_sh    = {rem_q[G_W-1:0], dvd_q[SUM_W-1]};
	assign ge        = rem_sh >= {1'b0, div_q};
	assign mag       = job_sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(job_sum)) : SUM_W'(job_sum);
	assign res       = neg_q ? (SUM_W'(0) - dvd_q) : dvd_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bavg_pkg::ST_IDLE: begin
				if (job_valid) begin
					state_d = bavg_pkg::ST_DIV;
				end
			end
			bavg_pkg::ST_DIV: begin
				if (last_iter) begin
					state_d = bavg_pkg::ST_DONE;
				end
			end
			bavg_pkg::ST_DONE: begin
				if (!out_valid_q || mean_ready) begin
					state_d = bavg_pkg::ST_IDLE;
				end
			end
			default: state_d = bavg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		step      = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			bavg_pkg::ST_IDLE: job_ready = 1'b1;
			bavg_pkg::ST_DIV:  step      = 1'b1;
			bavg_pkg::ST_DONE: load_out  = !out_valid_q || mean_ready;
			default: begin
				job_ready = 1'b0;
			end
		endcase
	end

	assign load_job = job_ready & job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bavg_pkg::ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_job) begin
				iter_q <= '0;
			end else if (step) begin
				iter_q <= iter_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (mean_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			dvd_q <= mag;
			rem_q <= '0;
			div_q <= job_group;
			neg_q <= job_sum[SUM_W-1];
		end else if (step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
		end
		if (load_out) begin
			mean_q <= res[bavg_pkg::SAMPLE_W-1:0];
		end
	end

	assign mean_valid = out_valid_q;
	assign mean       = mean_q;

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bavg_pkg::ST_DIV) |-> (32'(iter_q) < SUM_W))
		else $error("divide step count out of range");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bavg_pkg::ST_DIV && last_iter) |=> (state_q == bavg_pkg::ST_DONE))
		else $error("divide did not finish after the last step");

endmodule

// ===== rtl/block_average_decimator.sv =====
// Top level of the block average decimator: group size register and stream channels.
//
//  channel   | dir | width | contents
//  s_axis    | in  | 24    | tdata[23:0] sample, two's complement
//  m_axis    | out | 24    | tdata[23:0] mean, two's complement
//  cfg_wr    | in  | 9     | group_size, 1..MAX_GROUP (0 acts as 1, above MAX_GROUP clamps)
//
// Samples transfer at one per cycle while the two-entry job queue has room.
// Each closed group goes through the bit-serial divider (ST_IDLE, ST_DIV, ST_DONE),
// which takes no new group until it has handed on the mean of the last one, so
// short groups fill the queue and slow the sample intake.
// Reset clears the sum, the count, the queue and the output valid, and sets group_size to 1.
// A stalled m_axis holds the mean; the divider and then the queue back up into s_axis.
module block_average_decimator #(
	parameter int MAX_GROUP = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bavg_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [23:0] sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bavg_pkg::SAMPLE_W-1:0] m_axis_tdata,  // [23:0] mean
	input  logic                          cfg_wr_en,
	input  logic [bavg_pkg::GSIZE_W-1:0]  cfg_wr_data
);

	localparam int CNT_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int SUM_W = bavg_pkg::SAMPLE_W + $clog2(MAX_GROUP);
	localparam int G_W   = $clog2(MAX_GROUP + 1);
	localparam int JOB_W = SUM_W + G_W;

	logic [bavg_pkg::GSIZE_W-1:0] group_size_q;
	logic [31:0]                  g_wide;
	logic [G_W-1:0]               group_eff;

	logic                    job_space;
	logic                    job_push;
	logic signed [SUM_W-1:0] push_sum;
	logic [G_W-1:0]          push_group;
	logic                    pop_valid;
	logic                    pop;
	logic [JOB_W-1:0]        pop_data;
	bavg_pkg::sample_t       mean;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= bavg_pkg::GSIZE_W'(1);
		end else if (cfg_wr_en) begin
			group_size_q <= cfg_wr_data;
		end
	end

	always_comb begin
		priority if (group_size_q == '0) begin
			g_wide = 32'd1;
		end else if (32'(group_size_q) > MAX_GROUP) begin
			g_wide = 32'(MAX_GROUP);
		end else begin
			g_wide = 32'(group_size_q);
		end
	end

	assign group_eff = g_wide[G_W-1:0];

	bavg_front #(
		.MAX_GROUP (MAX_GROUP),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W),
		.G_W       (G_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (s_axis_tvalid),
		.sample_ready (s_axis_tready),
		.sample       (bavg_pkg::sample_t'(s_axis_tdata)),
		.group_eff    (group_eff),
		.job_space    (job_space),
		.job_push     (job_push),
		.job_sum      (push_sum),
		.job_group    (push_group)
	);

	bavg_fifo #(
		.W (JOB_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data ({push_group, push_sum}),
		.space     (job_space),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	bavg_div #(
		.SUM_W (SUM_W),
		.G_W   (G_W)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (pop_valid),
		.job_ready  (pop),
		.job_sum    (pop_data[SUM_W-1:0]),
		.job_group  (pop_data[JOB_W-1:SUM_W]),
		.mean_valid (m_axis_tvalid),
		.mean_ready (m_axis_tready),
		.mean       (mean)
	);

	assign m_axis_tdata = mean;

endmodule
